/* rtl/ksic_pkg.sv */
package ksic_pkg;

    // index geometry
    localparam int INDEX_DEPTH = 4096;
    localparam int AW          = $clog2(INDEX_DEPTH);      // entry address
    localparam int CW          = $clog2(INDEX_DEPTH + 1);  // entry count, holds the depth
    localparam int KMER_LEN    = 31;
    localparam int KEY_W       = 62;
    localparam int KEY_BITS    = 2 * KMER_LEN;
    localparam int CNT_W       = 16;
    localparam int POS_W       = 12;
    localparam int KIND_W      = 2;
    localparam int STAT_W      = 2;

    localparam logic [KEY_W-1:0] KEY_MASK =
        KEY_W'((65'(1) << KEY_BITS) - 65'(1));
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CW-1:0]    DEPTH_CNT = CW'(INDEX_DEPTH);

    // stream word widths
    localparam int IN_DATA_W  = ((KEY_W + 7) / 8) * 8;
    localparam int OUT_FLD_W  = POS_W + 2 * CNT_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COUNT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    // result status
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FND  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_ORDER    = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic accept;       // latch incoming word, reset search window
        logic rd_last;      // read port addresses the last loaded entry
        logic search_step;  // narrow window from the key just read
        logic ld_new;       // append a new key
        logic ld_rmw;       // bump graph count of the last entry
        logic ld_order;     // out-of-order load result
        logic ld_full;      // full table result
        logic chk;          // finish lookup, bump read count on a count hit
        logic clr_step;     // zero one read count
        logic clr_done;     // clear result
        logic out_load;     // move result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_eq;
        logic last_lt;
        logic full;
        logic more;         // search window still open after this cycle
        logic sweep_done;
        logic out_free;
    } t_sts;

endpackage

/* rtl/ksic_ram.sv */
module ksic_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ksic_dp.sv */
module ksic_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ksic_pkg::t_cmd                 i_cmd,
    output ksic_pkg::t_sts                 o_sts,
    input  logic [ksic_pkg::KIND_W-1:0]    i_kind,
    input  logic [ksic_pkg::KEY_W-1:0]     i_key,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [ksic_pkg::STAT_W-1:0]    o_status,
    output logic [ksic_pkg::OUT_FLD_W-1:0] o_fields
);
    import ksic_pkg::*;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    endfunction

    // item registers
    logic [KIND_W-1:0] r_kind;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_last_key;
    logic [CW-1:0]     r_used, r_lo, r_hi;

    // result and output registers
    logic [STAT_W-1:0] r_res_st;
    logic [POS_W-1:0]  r_res_pos;
    logic [CNT_W-1:0]  r_res_g, r_res_r;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_st;
    logic [OUT_FLD_W-1:0] r_out_fld;

    // memory ports
    logic [AW-1:0]    rd_addr, last_addr, wr_addr;
    logic [KEY_W-1:0] key_q;
    logic [CNT_W-1:0] g_q, r_q, g_wdata, r_wdata;
    logic             g_we, r_we, found, is_count;

    // search window
    logic [CW-1:0] mid, n_lo, n_hi, n_mid;
    logic          key_below;

    assign mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign key_below = key_q < r_key;
    assign n_lo      = (i_cmd.search_step && key_below)  ? mid + CW'(1) : r_lo;
    assign n_hi      = (i_cmd.search_step && !key_below) ? mid : r_hi;
    assign n_mid     = n_lo + ((n_hi - n_lo) >> 1);
    assign last_addr = AW'(r_used - CW'(1));
    assign rd_addr   = i_cmd.rd_last ? last_addr
                     : (n_lo < n_hi) ? n_mid[AW-1:0] : n_lo[AW-1:0];

    assign found    = (r_lo < r_used) && (key_q == r_key);
    assign is_count = (r_kind == KIND_COUNT);

    // write steering
    assign wr_addr = i_cmd.ld_new ? r_used[AW-1:0] : r_lo[AW-1:0];
    assign g_we    = i_cmd.ld_new || i_cmd.ld_rmw;
    assign g_wdata = i_cmd.ld_new ? CNT_W'(1) : sat_inc(g_q);
    assign r_we    = i_cmd.ld_new || i_cmd.clr_step || (i_cmd.chk && found && is_count);
    assign r_wdata = i_cmd.chk ? sat_inc(r_q) : '0;

    ksic_ram #(.W(KEY_W), .DEPTH(INDEX_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_new),
        .i_waddr (r_used[AW-1:0]),
        .i_wdata (r_key),
        .i_raddr (rd_addr),
        .o_rdata (key_q)
    );

    ksic_ram #(.W(CNT_W), .DEPTH(INDEX_DEPTH)) u_graph_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (i_cmd.ld_new ? r_used[AW-1:0] : last_addr),
        .i_wdata (g_wdata),
        .i_raddr (rd_addr),
        .o_rdata (g_q)
    );

    ksic_ram #(.W(CNT_W), .DEPTH(INDEX_DEPTH)) u_read_ram (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (wr_addr),
        .i_wdata (r_wdata),
        .i_raddr (rd_addr),
        .o_rdata (r_q)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_lo <= '0;
                r_hi <= r_used;
            end else if (i_cmd.search_step) begin
                r_lo <= n_lo;
                r_hi <= n_hi;
            end else if (i_cmd.clr_step) begin
                r_lo <= r_lo + CW'(1);
            end
            if (i_cmd.ld_new) begin
                r_used <= r_used + CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_key  <= i_key & KEY_MASK;
        end
        if (i_cmd.ld_new) begin
            r_last_key <= r_key;
            r_res_st   <= ST_OK;
            r_res_pos  <= POS_W'(r_used);
            r_res_g    <= CNT_W'(1);
            r_res_r    <= '0;
        end else if (i_cmd.ld_rmw) begin
            r_res_st  <= ST_OK;
            r_res_pos <= POS_W'(last_addr);
            r_res_g   <= sat_inc(g_q);
            r_res_r   <= r_q;
        end else if (i_cmd.chk && found) begin
            r_res_st  <= ST_OK;
            r_res_pos <= POS_W'(r_lo);
            r_res_g   <= g_q;
            r_res_r   <= is_count ? sat_inc(r_q) : r_q;
        end else if (i_cmd.chk || i_cmd.ld_order || i_cmd.ld_full || i_cmd.clr_done) begin
            r_res_st  <= i_cmd.chk ? ST_NOT_FND : i_cmd.ld_order ? ST_ORDER
                       : i_cmd.ld_full ? ST_FULL : ST_OK;
            r_res_pos <= '0;
            r_res_g   <= '0;
            r_res_r   <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_st  <= r_res_st;
            r_out_fld <= {r_res_r, r_res_g, r_res_pos};
        end
    end

    assign o_sts.last_eq    = (r_used != '0) && (r_key == r_last_key);
    assign o_sts.last_lt    = (r_used != '0) && (r_key < r_last_key);
    assign o_sts.full       = (r_used == DEPTH_CNT);
    assign o_sts.more       = (n_lo < n_hi);
    assign o_sts.sweep_done = (r_lo == r_used);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_st;
    assign o_fields    = r_out_fld;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= DEPTH_CNT) else $error("entry count past depth");

    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_hi) else $error("search window inverted");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.ld_new, i_cmd.ld_rmw, i_cmd.ld_order, i_cmd.ld_full,
                  i_cmd.chk, i_cmd.clr_done}))
        else $error("two results formed at once");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_new |-> !o_sts.full) else $error("append into full table");

    a_used_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.ld_new |=> $stable(r_used)) else $error("entry count moved without append");

endmodule

/* rtl/ksic_ctrl.sv */
module ksic_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [ksic_pkg::KIND_W-1:0] i_kind,
    output logic                        o_in_ready,
    input  ksic_pkg::t_sts              i_sts,
    output ksic_pkg::t_cmd              o_cmd
);
    import ksic_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_LDRD  = 3'd2;
    localparam logic [2:0] S_SINIT = 3'd3;
    localparam logic [2:0] S_SRCH  = 3'd4;
    localparam logic [2:0] S_CHK   = 3'd5;
    localparam logic [2:0] S_CLR   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_kind == KIND_LOAD) begin
                        n_state = S_LOAD;
                    end else if (i_kind inside {KIND_COUNT, KIND_QUERY}) begin
                        n_state = S_SINIT;
                    end else begin
                        n_state = S_CLR;
                    end
                end
            end
            S_LOAD: begin
                n_state = S_FIN;
                if (i_sts.last_eq) begin
                    o_cmd.rd_last = 1'b1;
                    n_state       = S_LDRD;
                end else if (i_sts.last_lt) begin
                    o_cmd.ld_order = 1'b1;
                end else if (i_sts.full) begin
                    o_cmd.ld_full = 1'b1;
                end else begin
                    o_cmd.ld_new = 1'b1;
                end
            end
            S_LDRD: begin
                o_cmd.ld_rmw = 1'b1;
                n_state      = S_FIN;
            end
            S_SINIT: begin
                n_state = i_sts.more ? S_SRCH : S_CHK;
            end
            S_SRCH: begin
                o_cmd.search_step = 1'b1;
                n_state           = i_sts.more ? S_SRCH : S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = S_FIN;
            end
            S_CLR: begin
                if (i_sts.sweep_done) begin
                    o_cmd.clr_done = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.clr_step = 1'b1;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state != S_IDLE)) else $error("accept did not start work");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free) else $error("result loaded over pending word");

    a_step_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.search_step |-> $past(r_state == S_SINIT || r_state == S_SRCH))
        else $error("search step outside search");

endmodule

/* rtl/kmer_sorted_index_counter.sv */
// Channel   Dir  Signals          Word contents (low bit first)
// s_axis    in   tvalid/tready    tuser: kind[1:0]; tdata: kmer_key[61:0], zero pad to 64
// m_axis    out  tvalid/tready    tuser: status[1:0];
//                                 tdata: position[11:0], graph_count[15:0],
//                                 read_count[15:0], zero pad to 48
//
// One word in flight at a time; tready is high only while idle. Results sit in an
// output register, so the next word is taken while a result waits on m_axis.
// Count/query: lower-bound binary search, one key-RAM read per step with the
// compare feeding the next address until the search window closes.
// Load: appends the key; a repeated key takes a read-modify-write of the graph count.
// Clear: sweeps the read-count RAM over the loaded entries, zeroing each read count.
// Synchronous active-low reset empties the index; RAM contents are not cleared
// since every entry is written on load before it can be read.
module kmer_sorted_index_counter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [ksic_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,  // kmer_key, pad
    input  logic [ksic_pkg::KIND_W-1:0]      i_s_axis_tuser,  // kind
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [ksic_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,  // position, graph, read, pad
    output logic [ksic_pkg::STAT_W-1:0]      o_m_axis_tuser   // status
);
    import ksic_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic [OUT_FLD_W-1:0] out_fields;

    ksic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ksic_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_s_axis_tuser),
        .i_key       (i_s_axis_tdata[KEY_W-1:0]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_status    (o_m_axis_tuser),
        .o_fields    (out_fields)
    );

    // pad the result fields up to the byte-aligned word
    assign o_m_axis_tdata = OUT_DATA_W'(out_fields);

endmodule
